FILE: rtl/core/linear_probe_hash_table_core_defines.svh
// assertion macros for the hash table core
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
// assert that a implies b at the same edge
`define LPH_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b at the next edge
`define LPH_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/lph_pkg.sv
// package for the hash table core: widths, codes, hash constants
package lph_pkg;
  localparam int unsigned SlotBits = 4;
  localparam int unsigned Slots = 16;
  localparam int unsigned KeyBytes = 8;
  localparam int unsigned ValueBits = 32;
  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvMult = 64'h00000100000001B3;

  localparam logic [2:0] StUpdated = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StFound = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StInvalid = 3'd4;
  localparam logic [2:0] StFull = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [3:0]  slot_index;
  } rsp_t;
endpackage

FILE: rtl/core/lph_if.sv
// valid/ready channel interface carrying one word
interface lph_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lph_hash.sv
// iterative fnv-1a hash: one byte through a shared shift-add multiply per cycle
module lph_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  len_i,
  output logic        done_o,
  output logic [63:0] hash_o
);
  logic [63:0] h_q, h_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [63:0] x;
  logic [7:0]  b;

  // byte select and mix; the fnv prime is 2^40 + 0x1b3, so shifts and adds
  always_comb begin
    b = key_i[{cnt_q[2:0], 3'b000} +: 8];
    x = h_q ^ {56'd0, b};
    h_d = h_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      h_d = lph_pkg::FnvBasis;
      cnt_d = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == len_i) begin
        busy_d = 1'b0;
      end else begin
        h_d = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign done_o = busy_q && (cnt_q == len_i);
  assign hash_o = h_q;
endmodule

FILE: rtl/core/linear_probe_hash_table_core.sv
// top level of the hash table core: sequencer, slot store and result register
//  channel  dir  word   fields
//  req      in   req_t  kind key_bytes key_length write_value
//  rsp      out  rsp_t  status read_value slot_index
//  cfg      in   5 bit  load_limit via cfg_we_i / cfg_data_i
// one word is accepted, then hashed over key_length (clamped to 8) bytes with
// one multiply each before the hash is handed over, then probed one slot at a
// time (up to 16, then it gives up on a full table), and its result is held
// until rsp is taken; a set with zero value goes straight to the result.
// reset empties the table at once through per-slot used bits.
// req is not ready while a word is at work or a result waits to be taken.
`include "linear_probe_hash_table_core_defines.svh"
module linear_probe_hash_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  lph_if.sink        req,
  lph_if.source      rsp
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  lph_pkg::req_t req_q;
  lph_pkg::rsp_t rsp_q, rsp_d;
  logic [4:0] limit_q, count_q, count_d;
  logic [15:0] used_q, used_d;
  logic [63:0] key_q [16];
  logic [3:0] len_q [16];
  logic [31:0] val_q [16];
  logic [3:0] idx_q, idx_d;
  logic [4:0] n_q, n_d;
  logic wr_new, wr_val;
  logic [3:0] len_c;
  logic [63:0] mask_c, key_c;
  logic hash_start;
  logic hash_done;
  logic [63:0] hash;
  logic hit;

  // length clamp and key masking of the incoming word
  always_comb begin
    len_c = (req.data.key_length > 4'd8) ? 4'd8 : req.data.key_length;
    mask_c = (len_c >= 4'd8) ? '1 : ((64'd1 << {len_c, 3'b000}) - 64'd1);
    key_c = req.data.key_bytes & mask_c;
  end

  assign hash_start = (state_q == S_IDLE) && req.valid && req.ready
                      && (req.data.kind || (req.data.write_value != 32'd0));

  lph_hash u_hash (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(hash_start),
    .key_i(req_q.key_bytes), .len_i(req_q.key_length),
    .done_o(hash_done), .hash_o(hash)
  );

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_OUT);
  assign rsp.data = rsp_q;
  assign hit = used_q[idx_q] && (len_q[idx_q] == req_q.key_length)
               && (key_q[idx_q] == req_q.key_bytes);

  // sequencer
  always_comb begin
    state_d = state_q;
    rsp_d = rsp_q;
    idx_d = idx_q;
    n_d = n_q;
    count_d = count_q;
    used_d = used_q;
    wr_new = 1'b0;
    wr_val = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          if (hash_start) begin
            state_d = S_HASH;
          end else begin
            rsp_d = '{status: lph_pkg::StInvalid, read_value: 32'd0, slot_index: 4'd0};
            state_d = S_OUT;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d = hash[3:0];
          n_d = 5'd0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (n_q == 5'd16) begin
          rsp_d = '{status: req_q.kind ? lph_pkg::StNotFound : lph_pkg::StFull,
                    read_value: 32'd0, slot_index: 4'd0};
          state_d = S_OUT;
        end else if (!used_q[idx_q]) begin
          if (req_q.kind) begin
            rsp_d = '{status: lph_pkg::StNotFound, read_value: 32'd0, slot_index: 4'd0};
          end else if (count_q >= limit_q || count_q >= 5'd16) begin
            rsp_d = '{status: lph_pkg::StFull, read_value: 32'd0, slot_index: 4'd0};
          end else begin
            wr_new = 1'b1;
            used_d[idx_q] = 1'b1;
            count_d = count_q + 5'd1;
            rsp_d = '{status: lph_pkg::StInserted, read_value: 32'd0, slot_index: idx_q};
          end
          state_d = S_OUT;
        end else if (hit) begin
          if (req_q.kind) begin
            rsp_d = '{status: lph_pkg::StFound, read_value: val_q[idx_q], slot_index: idx_q};
          end else begin
            wr_val = 1'b1;
            rsp_d = '{status: lph_pkg::StUpdated, read_value: 32'd0, slot_index: idx_q};
          end
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + 4'd1;
          n_d = n_q + 5'd1;
        end
      end
      S_OUT: begin
        if (rsp.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= 5'd0;
      used_q <= 16'd0;
      limit_q <= 5'd8;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      used_q <= used_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
    end
  end

  // payload and slot store
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    idx_q <= idx_d;
    n_q <= n_d;
    if (state_q == S_IDLE) begin
      req_q <= '{kind: req.data.kind, key_bytes: key_c, key_length: len_c,
                 write_value: req.data.write_value};
    end
    if (wr_new) begin
      key_q[idx_q] <= req_q.key_bytes;
      len_q[idx_q] <= req_q.key_length;
    end
    if (wr_new || wr_val) val_q[idx_q] <= req_q.write_value;
  end

  `LPH_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= 5'd16)
  `LPH_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, wr_new, count_q == $past(count_q) + 5'd1)
  `LPH_ASSERT_IMP(a_hash_busy, clk_i, rst_ni, hash_done, state_q == S_HASH)
  `LPH_ASSERT_IMP(a_ins_empty, clk_i, rst_ni, wr_new, !used_q[idx_q])
endmodule

FILE: verif/testbench.sv
// self-checking testbench for the linear probing hash table core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindSet = 1'b0;
  localparam logic KindGet = 1'b1;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [4:0] cfg_data_i;

  lph_if #(.T(lph_pkg::req_t)) req ();
  lph_if #(.T(lph_pkg::rsp_t)) rsp ();

  linear_probe_hash_table_core u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // table model state
  logic        mdl_used [lph_pkg::Slots];
  logic [63:0] mdl_key [lph_pkg::Slots];
  logic [3:0]  mdl_len [lph_pkg::Slots];
  logic [31:0] mdl_val [lph_pkg::Slots];
  int unsigned mdl_count;
  logic [4:0]  mdl_limit;

  lph_pkg::req_t pending_words[$];
  lph_pkg::rsp_t expected_rsps[$];
  int   send_idle_pct;
  int   recv_idle_pct;
  int   errors;
  int   idle_cycles;
  logic [63:0] key_pool[$];

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // fnv-1a home slot over the masked key
  function automatic logic [3:0] home_slot(logic [63:0] key, logic [3:0] len);
    logic [63:0] h;
    h = lph_pkg::FnvBasis;
    for (int i = 0; i < len; i++) begin
      h = h ^ {56'd0, key[i*8 +: 8]};
      h = h * lph_pkg::FnvMult;
    end
    return h[3:0];
  endfunction

  // predict one table operation and update the model
  function automatic lph_pkg::rsp_t table_access(lph_pkg::req_t w);
    lph_pkg::rsp_t r;
    logic [3:0] len;
    logic [63:0] key;
    logic [3:0] idx;
    logic hit;
    logic empty;
    logic [3:0] slot;
    len = (w.key_length > lph_pkg::KeyBytes) ? 4'(lph_pkg::KeyBytes) : w.key_length;
    key = (len >= 8) ? w.key_bytes : (w.key_bytes & ((64'd1 << (len * 8)) - 64'd1));
    r = '0;
    hit = 1'b0;
    empty = 1'b0;
    slot = '0;
    if (w.kind == KindGet || w.write_value != 0) begin
      idx = home_slot(key, len);
      for (int n = 0; n < lph_pkg::Slots; n++) begin
        if (!mdl_used[idx]) begin
          empty = 1'b1;
          slot = idx;
          break;
        end
        if (mdl_len[idx] == len && mdl_key[idx] == key) begin
          hit = 1'b1;
          slot = idx;
          break;
        end
        idx = idx + 4'd1;
      end
    end
    if (w.kind == KindGet) begin
      if (hit) begin
        r.status = lph_pkg::StFound;
        r.read_value = mdl_val[slot];
        r.slot_index = slot;
      end else begin
        r.status = lph_pkg::StNotFound;
      end
    end else if (w.write_value == 0) begin
      r.status = lph_pkg::StInvalid;
    end else if (hit) begin
      mdl_val[slot] = w.write_value;
      r.status = lph_pkg::StUpdated;
      r.slot_index = slot;
    end else if (!empty || mdl_count >= mdl_limit || mdl_count >= lph_pkg::Slots) begin
      r.status = lph_pkg::StFull;
    end else begin
      mdl_used[slot] = 1'b1;
      mdl_key[slot] = key;
      mdl_len[slot] = len;
      mdl_val[slot] = w.write_value;
      mdl_count++;
      r.status = lph_pkg::StInserted;
      r.slot_index = slot;
    end
    return r;
  endfunction

  // driver: offers queued words, the offered word stays at the queue head
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.data <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(table_access(req.data));
        void'(pending_words.pop_front());
      end
      if (req.valid && !req.ready) begin
        // hold the offered word
      end else if (pending_words.size() != 0
                   && $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        req.data <= pending_words[0];
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor: random stall, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected word status=%0d", rsp.data.status);
          errors++;
        end else begin
          lph_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (e.status !== rsp.data.status) begin
            $error("status exp %0d got %0d", e.status, rsp.data.status);
            errors++;
          end
          if (e.read_value !== rsp.data.read_value) begin
            $error("read_value exp %0h got %0h", e.read_value, rsp.data.read_value);
            errors++;
          end
          if (e.slot_index !== rsp.data.slot_index) begin
            $error("slot_index exp %0d got %0d", e.slot_index, rsp.data.slot_index);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // random key with no zero byte within its length
  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) if (k[i*8 +: 8] == 8'd0) k[i*8 +: 8] = 8'd1;
    return k;
  endfunction

  function automatic lph_pkg::req_t make_word(logic kind, logic [63:0] key, logic [3:0] len,
                                              logic [31:0] value);
    lph_pkg::req_t w;
    w.kind = kind;
    w.key_bytes = key;
    w.key_length = len;
    w.write_value = value;
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_limit = value;
  endtask

  // one random word, mostly on known keys
  function automatic lph_pkg::req_t random_word();
    logic [63:0] key;
    logic [3:0] len;
    logic [31:0] value;
    int pick;
    pick = $urandom_range(99);
    if (key_pool.size() == 0 || pick < 30) begin
      key = fresh_key();
      if (pick < 3) key = {$urandom, $urandom};
      if (key_pool.size() < 40) key_pool.push_back(key);
    end else begin
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    end
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    value = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
    return make_word(1'($urandom_range(1)), key, len, value);
  endfunction

  task automatic random_phase(int count);
    repeat (count) pending_words.push_back(random_word());
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    errors = 0;
    send_idle_pct = 23;
    recv_idle_pct = 55;
    for (int i = 0; i < lph_pkg::Slots; i++) begin
      mdl_used[i] = 1'b0;
      mdl_key[i] = '0;
      mdl_len[i] = '0;
      mdl_val[i] = '0;
    end
    mdl_count = 0;
    mdl_limit = 5'd8;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty key, extremes, zero bytes, long length, invalid, update, full table
    pending_words.push_back(make_word(KindGet, 64'd0, 4'd0, 32'd0));
    pending_words.push_back(make_word(KindSet, 64'd0, 4'd0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(KindGet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd0));
    pending_words.push_back(make_word(KindSet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd1));
    pending_words.push_back(make_word(KindGet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0));
    pending_words.push_back(make_word(KindSet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'd7));
    pending_words.push_back(make_word(KindSet, 64'h0000_0000_0000_0000, 4'd3, 32'd5));
    pending_words.push_back(make_word(KindSet, 64'hAB00_0041, 4'd2, 32'd9));
    pending_words.push_back(make_word(KindGet, 64'hFF00_0041, 4'd2, 32'd0));
    pending_words.push_back(make_word(KindGet, 64'h0041, 4'd1, 32'd0));
    pending_words.push_back(make_word(KindSet, 64'h1234, 4'd2, 32'd0));
    pending_words.push_back(make_word(KindGet, 64'h1234, 4'd2, 32'd0));
    for (int i = 0; i < 8; i++)
      pending_words.push_back(make_word(KindSet, fresh_key(), 4'd8, 32'h8000_0000 | i));
    pending_words.push_back(make_word(KindSet, 64'h0000_0000_0000_0000, 4'd3, 32'd6));
    // sender holds off until everything is back
    drain();

    // full table with the limit at the slot count
    write_limit(5'd16);
    random_phase(300);
    send_idle_pct = 55;
    recv_idle_pct = 23;
    random_phase(300);
    drain();
    write_limit(5'd31);
    random_phase(300);
    drain();
    // limit zero refuses all inserts
    write_limit(5'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);
    drain();
    write_limit(5'd12);
    random_phase(580);
    drain();

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lph_pkg.sv
rtl/core/lph_if.sv
rtl/core/lph_hash.sv
rtl/core/linear_probe_hash_table_core.sv
verif/testbench.sv
